// ===== design/cbcs_pkg.sv =====
// Shared constants and types for the cubic Bezier curve solver.
// No dependencies; imported by cbcs_core and the top level.
package cbcs_pkg;

    localparam int DEF_PARAM_FRAC_BITS = 24;
    localparam int DEF_COORD_WIDTH     = 32;

    localparam int FIELD_W      = 32;
    localparam int NUM_IN_FIELD = 9;
    localparam int IN_TDATA_W   = FIELD_W * NUM_IN_FIELD;
    localparam int OUT_TDATA_W  = FIELD_W;
    localparam int OUT_TUSER_W  = 1;

    localparam int TOL_W      = 16;
    localparam int PASS_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd66;
    localparam logic [PASS_W-1:0] PASS_RESET = 8'd100;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PASSES = 1'd1;

    typedef struct packed {
        logic [FIELD_W-1:0] curve_value;
        logic               converged;
    } t_result;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_core_stat;

endpackage

// ===== design/cbcs_mul.sv =====
// Shared multiplier of the solver: unsigned fraction times signed operand,
// product registered. Depends on nothing but its parameters.
module cbcs_mul #(
    parameter int A_W = 26,
    parameter int B_W = 32
) (
    input  logic                      i_clk,
    input  logic [A_W-1:0]            i_a,
    input  logic signed [B_W-1:0]     i_b,
    output logic signed [A_W+B_W:0]   o_prod
);

    logic signed [A_W+B_W:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed({1'b0, i_a}) * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== design/cbcs_core.sv =====
// Bisection engine: sequencer, parameter bounds, Bernstein weights and
// accumulators around one shared multiplier. Uses cbcs_pkg and cbcs_mul.
module cbcs_core #(
    parameter int FRAC_BITS  = cbcs_pkg::DEF_PARAM_FRAC_BITS,
    parameter int COORD_BITS = cbcs_pkg::DEF_COORD_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [cbcs_pkg::IN_TDATA_W-1:0]     i_points,
    input  logic [cbcs_pkg::TOL_W-1:0]          i_tolerance,
    input  logic [cbcs_pkg::PASS_W-1:0]         i_max_passes,
    input  logic                                i_res_ready,
    output cbcs_pkg::t_core_stat                o_stat,
    output cbcs_pkg::t_result                   o_res
);
    import cbcs_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int W  = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int WA = F + 2;                      // weights, up to 3.0
    localparam int BW = (W > F + 2) ? W : F + 2;
    localparam int PW = WA + BW + 1;
    localparam int AW = PW + 2;                     // four-term sum
    localparam int YW = AW - F;                     // floored Q16.16 value
    localparam int DW = YW + 1;

    localparam logic [F-1:0] U_INIT = {1'b1, {(F-1){1'b0}}};
    localparam logic [F:0]   ONE    = {1'b1, {F{1'b0}}};

    localparam logic signed [YW-1:0] Y_HI = YW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [YW-1:0] Y_LO = -Y_HI - YW'(1);

    // step = which product is issued to the multiplier this cycle
    localparam logic [3:0] ST_VV  = 4'd0;
    localparam logic [3:0] ST_UU  = 4'd1;
    localparam logic [3:0] ST_W0  = 4'd2;
    localparam logic [3:0] ST_W1  = 4'd3;
    localparam logic [3:0] ST_W2  = 4'd4;
    localparam logic [3:0] ST_W3  = 4'd5;
    localparam logic [3:0] ST_X0  = 4'd6;
    localparam logic [3:0] ST_X1  = 4'd7;
    localparam logic [3:0] ST_X2  = 4'd8;
    localparam logic [3:0] ST_X3  = 4'd9;
    localparam logic [3:0] ST_Y0  = 4'd10;
    localparam logic [3:0] ST_Y1  = 4'd11;
    localparam logic [3:0] ST_Y2  = 4'd12;
    localparam logic [3:0] ST_Y3  = 4'd13;
    localparam logic [3:0] ST_DEC = 4'd14;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_step, n_step;

    logic [F-1:0]          r_u, r_lower, n_u, n_lower;
    logic [F:0]            r_upper, n_upper;
    logic [PASS_W-1:0]     r_passes;
    logic [WA-1:0]         r_vv, r_uu, r_w0, r_w1, r_w2, r_w3;
    logic signed [W-1:0]   r_cx [4];
    logic signed [W-1:0]   r_cy [4];
    logic signed [W-1:0]   r_q;
    logic signed [AW-1:0]  r_acc_x, r_acc_y;
    logic                  r_conv;

    logic [F:0]            w_v;
    logic [WA-1:0]         w_a;
    logic signed [BW-1:0]  w_b;
    logic signed [PW-1:0]  w_prod;
    logic signed [AW-1:0]  w_prod_ext;
    logic [WA-1:0]         w_frac, w_frac3;
    logic signed [YW-1:0]  w_x, w_qx, w_y, w_ysat;
    logic signed [DW-1:0]  w_diff;
    logic [DW-1:0]         w_adiff;
    logic                  w_conv, w_lt, w_gt, w_stop;
    logic [F:0]            w_span, w_unext;

    assign w_v = ONE - {1'b0, r_u};

    // operand select for the shared multiplier
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_step)
            ST_VV: begin w_a = WA'(w_v);  w_b = BW'(w_v);  end
            ST_UU: begin w_a = WA'(r_u);  w_b = BW'(r_u);  end
            ST_W0: begin w_a = r_vv;      w_b = BW'(w_v);  end
            ST_W1: begin w_a = r_vv;      w_b = BW'(r_u);  end
            ST_W2: begin w_a = WA'(w_v);  w_b = BW'(r_uu); end
            ST_W3: begin w_a = r_uu;      w_b = BW'(r_u);  end
            ST_X0: begin w_a = r_w0;      w_b = BW'(r_cx[0]); end
            ST_X1: begin w_a = r_w1;      w_b = BW'(r_cx[1]); end
            ST_X2: begin w_a = r_w2;      w_b = BW'(r_cx[2]); end
            ST_X3: begin w_a = r_w3;      w_b = BW'(r_cx[3]); end
            ST_Y0: begin w_a = r_w0;      w_b = BW'(r_cy[0]); end
            ST_Y1: begin w_a = r_w1;      w_b = BW'(r_cy[1]); end
            ST_Y2: begin w_a = r_w2;      w_b = BW'(r_cy[2]); end
            ST_Y3: begin w_a = r_w3;      w_b = BW'(r_cy[3]); end
            default: begin w_a = '0;      w_b = '0;        end
        endcase
    end

    cbcs_mul #(
        .A_W (WA),
        .B_W (BW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    assign w_prod_ext = AW'(w_prod);
    assign w_frac     = w_prod[F+WA-1:F];           // floor of fraction product
    assign w_frac3    = w_frac + (w_frac << 1);

    // decision on the finished x sum
    assign w_x     = r_acc_x[AW-1:F];               // arithmetic floor
    assign w_qx    = YW'(r_q);
    assign w_diff  = DW'(w_qx) - DW'(w_x);
    assign w_adiff = w_diff[DW-1] ? DW'(-w_diff) : DW'(w_diff);
    assign w_conv  = (w_adiff <= DW'(i_tolerance));
    assign w_lt    = (w_x < w_qx);
    assign w_gt    = (w_x > w_qx);
    assign w_stop  = w_conv || !(r_passes < i_max_passes);

    assign n_lower = w_lt ? r_u : r_lower;
    assign n_upper = w_gt ? {1'b0, r_u} : r_upper;
    assign w_span  = n_upper - {1'b0, n_lower};
    assign w_unext = {1'b0, n_lower} + (w_span >> 1);
    assign n_u     = w_unext[F-1:0];

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_step  = ST_VV;
                end
            end
            S_RUN: begin
                if (r_step == ST_DEC) begin
                    n_step = ST_VV;
                    if (w_stop) begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = ST_VV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_VV;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            for (int k = 0; k < 4; k++) begin
                r_cx[k] <= i_points[(2*k)*FIELD_W +: W];
                r_cy[k] <= i_points[(2*k+1)*FIELD_W +: W];
            end
            r_q      <= i_points[(NUM_IN_FIELD-1)*FIELD_W +: W];
            r_u      <= U_INIT;
            r_lower  <= '0;
            r_upper  <= ONE;
            r_passes <= '0;
        end
        if (r_state == S_RUN) begin
            case (r_step)
                ST_UU:  r_vv    <= w_frac;
                ST_W0:  r_uu    <= w_frac;
                ST_W1:  r_w0    <= w_frac;
                ST_W2:  r_w1    <= w_frac3;
                ST_W3:  r_w2    <= w_frac3;
                ST_X0:  r_w3    <= w_frac;
                ST_X1:  r_acc_x <= w_prod_ext;
                ST_X2,
                ST_X3,
                ST_Y0:  r_acc_x <= r_acc_x + w_prod_ext;
                ST_Y1:  r_acc_y <= w_prod_ext;
                ST_Y2,
                ST_Y3:  r_acc_y <= r_acc_y + w_prod_ext;
                ST_DEC: begin
                    r_acc_y  <= r_acc_y + w_prod_ext;
                    r_conv   <= w_conv;
                    r_u      <= n_u;
                    r_lower  <= n_lower;
                    r_upper  <= n_upper;
                    r_passes <= r_passes + PASS_W'(1);
                end
                default: ;
            endcase
        end
    end

    // saturate y to the coordinate range
    assign w_y    = r_acc_y[AW-1:F];
    assign w_ysat = (w_y > Y_HI) ? Y_HI : ((w_y < Y_LO) ? Y_LO : w_y);

    assign o_res.curve_value = FIELD_W'(w_ysat);
    assign o_res.converged   = r_conv;
    assign o_stat.idle       = (r_state == S_IDLE);
    assign o_stat.res_valid  = (r_state == S_DONE);

endmodule

// ===== design/cubic_bezier_curve_solver_top.sv =====
// Cubic Bezier solver top: stream ports, configuration registers, output stage.
// A search runs N = min(passes to converge, max_passes + 1) passes; m_axis_tvalid
// rises from the output register after the decision step of the last pass.
// Items are searched one at a time on the single shared multiplier
// (14 products and one decision step per pass). Not ready from acceptance until the result enters the output register.
// Reset (synchronous, active low): idle, output empty, tolerance 66, max_passes 100.
module cubic_bezier_curve_solver_top #(
    parameter int PARAM_FRAC_BITS = cbcs_pkg::DEF_PARAM_FRAC_BITS,
    parameter int COORD_WIDTH     = cbcs_pkg::DEF_COORD_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, query_time (32 b each)
    input  logic [cbcs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // curve_value (32 b)
    output logic [cbcs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // converged (1 b)
    output logic [cbcs_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_we,
    input  logic [cbcs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cbcs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import cbcs_pkg::*;

    logic [TOL_W-1:0]  r_tolerance;
    logic [PASS_W-1:0] r_max_passes;
    logic              r_out_valid;
    t_result           r_out;
    t_core_stat        w_stat;
    t_result           w_res;
    logic              w_res_ready;
    logic              w_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance  <= TOL_RESET;
            r_max_passes <= PASS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOLERANCE:  r_tolerance  <= i_cfg_wdata[TOL_W-1:0];
                CFG_MAX_PASSES: r_max_passes <= i_cfg_wdata[PASS_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = w_stat.idle;
    assign w_start       = s_axis_tvalid && w_stat.idle;
    assign w_res_ready   = !r_out_valid || m_axis_tready;

    cbcs_core #(
        .FRAC_BITS  (PARAM_FRAC_BITS),
        .COORD_BITS (COORD_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_points     (s_axis_tdata),
        .i_tolerance  (r_tolerance),
        .i_max_passes (r_max_passes),
        .i_res_ready  (w_res_ready),
        .o_stat       (w_stat),
        .o_res        (w_res)
    );

    // output register; the core may start the next item while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out.curve_value;
    assign m_axis_tuser[0] = r_out.converged;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice without a search in between");

    a_out_from_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_stat.res_valid))
        else $error("output valid without a finished search");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.res_valid && !w_res_ready) |=> (w_stat.res_valid && $stable(w_res)))
        else $error("core result dropped or changed while output stage full");
`endif

endmodule
